>>> hw/rtl/hps_pkg.sv
// Shared types and constants for the host power sequencer.
`timescale 1ns / 1ps
package hps_pkg;
	localparam int unsigned PERIOD_W  = 20;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned THRESH_W  = 30;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned MS_PER_S  = 1000;

	localparam logic [CFG_IDX_W-1:0] REG_POWER  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WAKEUP = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_REBOOT = CFG_IDX_W'(3);

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_WAIT   = 2'd1,
		MODE_AWAKE  = 2'd2,
		MODE_REBOOT = 2'd3
	} mode_t;

	// Timeouts pre-scaled to milliseconds; zero disables.
	typedef struct packed {
		logic [THRESH_W-1:0] off_ms;
		logic [THRESH_W-1:0] power_ms;
		logic [THRESH_W-1:0] reboot_ms;
	} thresh_t;

	typedef struct packed {
		mode_t mode;
		logic  power_enable;
		logic  timed_out;
	} result_t;

	// floor(e / 1000) >= p holds exactly when e >= p * 1000
	function automatic logic [THRESH_W-1:0] to_ms(input logic [PERIOD_W-1:0] p);
		return THRESH_W'(p) * THRESH_W'(MS_PER_S);
	endfunction
endpackage

>>> hw/rtl/host_power_sequencer.sv
// A request is registered into the input stage, and its result into the output register.
// Throughput: one request per cycle while results are taken; the state feedback
// (32-bit elapsed subtract and threshold compare) is combinational between state registers.
// Output register lets the input stage take one more request while a result waits to be taken.
// Reset: waiting for status, power low, entry time zero, all periods zero.
// Top level of the host power sequencer.
`timescale 1ns / 1ps
module host_power_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hps_pkg::PERIOD_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hps_pkg::TIME_W-1:0]    now_ms,
	input  logic                          status_pin,
	input  logic                          turn_on,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    mode,
	output logic                          power_enable,
	output logic                          timed_out
);
	import hps_pkg::*;

	thresh_t           thresh;
	result_t           res;
	result_t           res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic [TIME_W-1:0] now_s1;
	logic              status_s1;
	logic              turn_on_s1;
	logic              adv_s2;
	logic              step_en;

	assign cfg_ready = 1'b1;

	hps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.thresh   (thresh)
	);

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign step_en  = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1     <= now_ms;
			status_s1  <= status_pin;
			turn_on_s1 <= turn_on;
		end
		if (step_en) begin
			res_s2 <= res;
		end
	end

	hps_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.now_ms     (now_s1),
		.status_pin (status_s1),
		.turn_on    (turn_on_s1),
		.thresh     (thresh),
		.res        (res)
	);

	assign out_valid    = valid_s2;
	assign mode         = res_s2.mode;
	assign power_enable = res_s2.power_enable;
	assign timed_out    = res_s2.timed_out;
endmodule

>>> hw/rtl/hps_cfg.sv
// Configuration registers, held as millisecond thresholds.
`timescale 1ns / 1ps
module hps_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [hps_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [hps_pkg::PERIOD_W-1:0]     wr_data,
	output hps_pkg::thresh_t                 thresh
);
	import hps_pkg::*;

	logic [THRESH_W-1:0] power_ms_q;
	logic [THRESH_W-1:0] sleep_ms_q;
	logic [THRESH_W-1:0] wakeup_ms_q;
	logic [THRESH_W-1:0] reboot_ms_q;
	logic [THRESH_W-1:0] off_ms_q;
	logic [THRESH_W-1:0] wr_ms;

	assign wr_ms = to_ms(wr_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_ms_q  <= '0;
			sleep_ms_q  <= '0;
			wakeup_ms_q <= '0;
			reboot_ms_q <= '0;
			off_ms_q    <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_POWER: power_ms_q <= wr_ms;
				REG_SLEEP: begin
					sleep_ms_q <= wr_ms;
					// off state uses the shorter of the two limits
					off_ms_q   <= (wakeup_ms_q < wr_ms) ? wakeup_ms_q : wr_ms;
				end
				REG_WAKEUP: begin
					wakeup_ms_q <= wr_ms;
					off_ms_q    <= (wr_ms < sleep_ms_q) ? wr_ms : sleep_ms_q;
				end
				REG_REBOOT: reboot_ms_q <= wr_ms;
				default: ;
			endcase
		end
	end

	assign thresh.off_ms    = off_ms_q;
	assign thresh.power_ms  = power_ms_q;
	assign thresh.reboot_ms = reboot_ms_q;
endmodule

>>> hw/rtl/hps_core.sv
// Sequencer state and next-state logic for one poll.
`timescale 1ns / 1ps
module hps_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [hps_pkg::TIME_W-1:0]    now_ms,
	input  logic                          status_pin,
	input  logic                          turn_on,
	input  hps_pkg::thresh_t              thresh,
	output hps_pkg::result_t              res
);
	import hps_pkg::*;

	mode_t               mode_q;
	logic [TIME_W-1:0]   entry_q;
	logic                power_q;

	logic [TIME_W-1:0]   elapsed;
	logic [THRESH_W-1:0] limit;
	mode_t               to_mode;
	mode_t               go_mode;
	mode_t               next_mode;
	logic                go;
	logic                hit;
	logic                tmo;
	logic                next_power;

	assign elapsed = now_ms - entry_q;

	always_comb begin
		limit      = thresh.power_ms;
		to_mode    = MODE_OFF;
		go_mode    = mode_q;
		go         = 1'b0;
		next_power = power_q;
		unique case (mode_q)
			MODE_OFF: begin
				limit      = thresh.off_ms;
				to_mode    = MODE_WAIT;
				next_power = 1'b0;
				go         = turn_on;
				go_mode    = MODE_WAIT;
			end
			MODE_WAIT: begin
				next_power = 1'b1;
				go         = status_pin;
				go_mode    = MODE_AWAKE;
			end
			MODE_AWAKE: begin
				go      = !status_pin;
				go_mode = MODE_REBOOT;
			end
			MODE_REBOOT: begin
				limit   = thresh.reboot_ms;
				go      = status_pin;
				go_mode = MODE_AWAKE;
			end
			default: ;
		endcase
	end

	// a transition reloads the entry time, so it masks the timeout
	assign hit       = (limit != '0) && (TIME_W'(limit) <= elapsed);
	assign tmo       = !go && hit;
	assign next_mode = tmo ? to_mode : (go ? go_mode : mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WAIT;
			entry_q <= '0;
			power_q <= 1'b0;
		end else if (step_en) begin
			mode_q  <= next_mode;
			power_q <= next_power;
			if (go || tmo) begin
				entry_q <= now_ms;
			end
		end
	end

	assign res.mode         = next_mode;
	assign res.power_enable = next_power;
	assign res.timed_out    = tmo;

	a_off_tmo_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && tmo && mode_q == MODE_OFF |=> mode_q == MODE_WAIT)
		else $error("off timeout did not move to waiting");

	a_tmo_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && (go || tmo) |=> entry_q == $past(now_ms))
		else $error("entry time not reloaded on state change");

	a_wait_powers: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && mode_q == MODE_WAIT |=> power_q)
		else $error("power not raised in waiting state");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(mode_q) && $stable(entry_q) && $stable(power_q))
		else $error("state changed without a request");
endmodule

>>> verif/host_power_sequencer_tb.sv
// Self-checking testbench for the host power sequencer with a built-in state predictor.
`timescale 1ns / 1ps
module host_power_sequencer_tb;
	import hps_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned POLLS_PER_PHASE = 210;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PATTERN,
		RX_SLOW
	} rx_style_e;

	// Tracks sequencer state and holds the results that accepted polls must produce.
	class power_seq_scoreboard;
		logic [PERIOD_W-1:0] power_s, sleep_s, wakeup_s, reboot_s;
		mode_t               cur_mode;
		logic [TIME_W-1:0]   entered_ms;
		logic                supply_on;
		result_t             due_results[$];
		int unsigned         errors;

		function new();
			power_s = '0;
			sleep_s = '0;
			wakeup_s = '0;
			reboot_s = '0;
			cur_mode = MODE_WAIT;
			entered_ms = '0;
			supply_on = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] data);
			case (idx)
				REG_POWER: power_s = data;
				REG_SLEEP: sleep_s = data;
				REG_WAKEUP: wakeup_s = data;
				REG_REBOOT: reboot_s = data;
				default: ;
			endcase
		endfunction

		function void move_to(mode_t next, logic [TIME_W-1:0] now);
			cur_mode = next;
			entered_ms = now;
		endfunction

		function void note_poll(logic [TIME_W-1:0] now, logic status, logic request);
			logic [PERIOD_W-1:0] limit;
			mode_t               on_expiry;
			logic [TIME_W-1:0]   held_ms;
			logic [TIME_W-1:0]   held_s;
			result_t             r;
			r.timed_out = 1'b0;
			on_expiry = MODE_OFF;
			case (cur_mode)
				MODE_OFF: begin
					limit = (wakeup_s < sleep_s) ? wakeup_s : sleep_s;
					on_expiry = MODE_WAIT;
					supply_on = 1'b0;
					if (request)
						move_to(MODE_WAIT, now);
				end
				MODE_WAIT: begin
					limit = power_s;
					supply_on = 1'b1;
					if (status)
						move_to(MODE_AWAKE, now);
				end
				MODE_AWAKE: begin
					limit = power_s;
					if (!status)
						move_to(MODE_REBOOT, now);
				end
				default: begin
					limit = reboot_s;
					if (status)
						move_to(MODE_AWAKE, now);
				end
			endcase
			if (limit != '0) begin
				// wrapping difference, floor to whole seconds
				held_ms = now - entered_ms;
				held_s = held_ms / MS_PER_S;
				if (held_s >= TIME_W'(limit)) begin
					move_to(on_expiry, now);
					r.timed_out = 1'b1;
				end
			end
			r.mode = cur_mode;
			r.power_enable = supply_on;
			due_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] m, logic pe, logic to);
			result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: result with no poll pending: mode %0d power %0b timeout %0b",
					$time, m, pe, to);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (m !== want.mode) begin
				$display("%0t: mode expected %0d actual %0d", $time, want.mode, m);
				errors++;
			end
			if (pe !== want.power_enable) begin
				$display("%0t: power_enable expected %0b actual %0b",
					$time, want.power_enable, pe);
				errors++;
			end
			if (to !== want.timed_out) begin
				$display("%0t: timed_out expected %0b actual %0b", $time, want.timed_out, to);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PERIOD_W-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [TIME_W-1:0]    now_ms = '0;
	logic                 status_pin = 1'b0;
	logic                 turn_on = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           mode;
	logic                 power_enable;
	logic                 timed_out;

	power_seq_scoreboard tracker = new();

	int unsigned       cycle_count = 0;
	int unsigned       burst_left = 0;
	logic [TIME_W-1:0] clock_ms = '0;
	logic              status_level = 1'b0;

	rx_style_e   rx_style = RX_OPEN;
	logic [7:0]  rx_pattern = 8'hFF;
	int unsigned rx_tick = 0;

	host_power_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.now_ms(now_ms),
		.status_pin(status_pin),
		.turn_on(turn_on),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode(mode),
		.power_enable(power_enable),
		.timed_out(timed_out)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				tracker.note_poll(now_ms, status_pin, turn_on);
			if (out_valid && out_ready)
				tracker.check_result(mode, power_enable, timed_out);
		end
	end

	// Receiver: drive out_ready under a randomly picked stall style.
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 64 == 0) begin
			rx_style <= rx_style_e'($urandom_range(0, 3));
			rx_pattern <= 8'($urandom) | 8'h01;
		end
		case (rx_style)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_PATTERN: out_ready <= rx_pattern[rx_tick % 8];
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("host_power_sequencer test failed");
		$finish;
	end

	task automatic set_period(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_poll(input logic [TIME_W-1:0] at_ms, input logic status,
			input logic request);
		@(negedge clk);
		in_valid <= 1'b1;
		now_ms <= at_ms;
		status_pin <= status;
		turn_on <= request;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid, wait for every pending result, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period(int unsigned flavor);
		case (flavor % 4)
			0: return PERIOD_W'($urandom_range(1, 3));
			1: return ($urandom_range(0, 1) != 0) ? PERIOD_W'($urandom_range(1, 5)) : '0;
			2: return ($urandom_range(0, 2) == 0) ? PERIOD_MAX : PERIOD_W'($urandom_range(1, 4));
			default: return PERIOD_W'($urandom);
		endcase
	endfunction

	// Advance the poll time: mostly short steps, some near second boundaries,
	// some long jumps and some arbitrary (possibly earlier) timestamps.
	task automatic step_clock();
		case ($urandom_range(0, 19))
			0: clock_ms = $urandom;
			1: clock_ms += $urandom_range(32'd1000000000, 32'd1100000000);
			2, 3: clock_ms += MS_PER_S * $urandom_range(0, 5) + $urandom_range(0, 2) - 1;
			default: clock_ms += $urandom_range(0, 1500);
		endcase
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all timeouts disabled: walk the status transitions
		send_poll(32'd0, 1'b0, 1'b1);
		send_poll(32'hFFFF_FFFF, 1'b1, 1'b0);
		send_poll(32'd5, 1'b0, 1'b1);
		send_poll(32'd6, 1'b1, 1'b0);
		send_poll(32'd7, 1'b0, 1'b0);
		drain();

		set_period(REG_POWER, 20'd1);
		set_period(REG_SLEEP, 20'd3);
		set_period(REG_WAKEUP, 20'd2);
		set_period(REG_REBOOT, 20'd1);
		set_period(CFG_IDX_W'(15), PERIOD_MAX);
		set_period(CFG_IDX_W'(8), '0);
		send_poll(32'd1007, 1'b0, 1'b0);
		send_poll(32'd1500, 1'b1, 1'b0);
		send_poll(32'd3006, 1'b1, 1'b0);
		send_poll(32'd3007, 1'b0, 1'b0);
		send_poll(32'd4006, 1'b0, 1'b0);
		send_poll(32'd4007, 1'b0, 1'b0);
		send_poll(32'd4008, 1'b0, 1'b1);
		send_poll(32'd4009, 1'b1, 1'b0);
		// timestamp behind entry time reads as a huge elapsed time
		send_poll(32'd2000, 1'b1, 1'b0);
		send_poll(32'd2001, 1'b0, 1'b1);
		drain();

		set_period(REG_POWER, PERIOD_MAX);
		set_period(REG_SLEEP, PERIOD_MAX);
		set_period(REG_WAKEUP, PERIOD_MAX);
		set_period(REG_REBOOT, PERIOD_MAX);
		send_poll(32'd2001 + 32'd1048574999, 1'b0, 1'b0);
		send_poll(32'd2001 + 32'd1048575000, 1'b0, 1'b0);
		send_poll(32'd2001 + 32'd2097150000, 1'b0, 1'b0);
		send_poll(32'd2001 + 32'd2097150001, 1'b1, 1'b0);
		clock_ms = 32'd2001 + 32'd2097150001;
		drain();

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			set_period(REG_POWER, pick_period(phase));
			set_period(REG_SLEEP, pick_period(phase + $urandom_range(0, 3)));
			set_period(REG_WAKEUP, pick_period(phase));
			set_period(REG_REBOOT, pick_period(phase));
			set_period(CFG_IDX_W'($urandom_range(4, 15)), PERIOD_W'($urandom));
			repeat (POLLS_PER_PHASE) begin
				pace();
				step_clock();
				if ($urandom_range(0, 3) == 0)
					status_level = ~status_level;
				send_poll(clock_ms, status_level, $urandom_range(0, 9) < 3);
			end
			drain();
		end

		if (tracker.errors == 0 && tracker.due_results.size() == 0)
			$display("host_power_sequencer test passed");
		else
			$display("host_power_sequencer test failed");
		$finish;
	end
endmodule
